/* design/sli_pkg.sv */
// Shared types and codes for the sorted insertion list.
// Used by sli_ram and sorted_list_insert_dump; depends on nothing.
package sli_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ENTRY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  // Input kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  // One stored pair; key sits in the low bits so it packs straight onto tdata
  typedef struct packed {
    logic signed [KEY_W-1:0] payload;
    logic signed [KEY_W-1:0] key;
  } entry_t;

endpackage

/* design/sli_ram.sv */
// Single-port-write, single-port-read entry store with registered read data.
// Depends on sli_pkg for the entry type.
module sli_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sli_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sli_pkg::entry_t rd_data
);
  import sli_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sorted_list_insert_dump.sv */
// Sorted insertion list: a bounded list of key/payload pairs in ascending
// signed key order.
// Usage:
//   in_*  : one transaction is an insert (tuser 0) or a dump (tuser 1).
//           tdata carries the key (bits 31:0) and payload (bits 63:32).
//   out_* : result transactions; tuser is the status, tlast marks the final
//           result of an input, tdata carries the dumped key and payload.
// Timing:
//   An insert into an empty or a full list is settled at acceptance.
//   Otherwise the new pair is placed by walking down from the tail, one
//   entry per cycle through the single read and write port: the tail is
//   read at acceptance, each entry that moves up is written one place
//   higher, and then the pair is written. An insert's status waits in the
//   pending status register, holding off the input, until the result
//   register is free. A dump streams one entry per cycle after a registered
//   read while the receiver takes them; an empty list gives one status.
// Reset: rst_n (synchronous, active low) empties the list at once; only
//   written entries are read, so the store needs no clearing pass.
// Stalls: a result register and a pending status register part the two
//   sides; a stalled receiver holds the dump read and drops in_tready.
module sorted_list_insert_dump #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [63:0]              in_tdata,   // entry_key[31:0], entry_payload[63:32]
  input  logic                     in_tuser,   // kind[0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [63:0]              out_tdata,  // out_key[31:0], out_payload[63:32]
  output logic [1:0]               out_tuser,  // status[1:0]
  output logic                     out_tlast   // last
);
  import sli_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  entry_t              new_r, new_nxt;
  logic                pend_r, pend_nxt;
  logic [STATUS_W-1:0] pend_stat_r, pend_stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  entry_t              out_data_r, out_data_nxt;
  logic [STATUS_W-1:0] out_stat_r, out_stat_nxt;
  logic                out_last_r, out_last_nxt;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  entry_t              wr_data, rd_data;
  entry_t              in_entry;
  logic                in_acc, out_free, is_full, dump_last;

  sli_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_entry  = entry_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE) && !pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign is_full   = (count_r == CW'(CAPACITY));
  assign dump_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    pend_nxt      = pend_r;
    pend_stat_nxt = pend_stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = '0;

    // drop the result register once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // advance a pending status into the result register
    if (pend_r && out_free && (state_r != S_DUMP)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_stat_nxt  = pend_stat_r;
      out_last_nxt  = 1'b1;
      pend_nxt      = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt = in_entry;
          if (in_tuser == KIND_INSERT) begin
            pend_nxt = 1'b1;
            if (is_full) begin
              pend_stat_nxt = STAT_FULL;
            end else if (count_r == '0) begin
              pend_stat_nxt = STAT_INSERTED;
              wr_en         = 1'b1;
              wr_addr       = '0;
              wr_data       = in_entry;
              count_nxt     = count_r + CW'(1);
            end else begin
              pend_stat_nxt = STAT_INSERTED;
              rd_en         = 1'b1;
              rd_addr       = AW'(count_r - CW'(1));
              idx_nxt       = AW'(count_r - CW'(1));
              state_nxt     = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              pend_nxt      = 1'b1;
              pend_stat_nxt = STAT_EMPTY;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = S_DUMP;
            end
          end
        end
      end

      S_INS: begin
        // rd_data holds entry idx_r; move it up or drop the new pair above it
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_data.key < new_r.key) begin
          wr_data   = new_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_IDLE;
        end else begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end
      end

      S_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_IDLE;
      end

      S_DUMP: begin
        // hold the read data until the result register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data;
          out_stat_nxt  = STAT_ENTRY;
          out_last_nxt  = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    new_r       <= new_nxt;
    pend_stat_r <= pend_stat_nxt;
    out_data_r  <= out_data_nxt;
    out_stat_r  <= out_stat_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) && $past(rst_n) |-> count_r == $past(count_r) + CW'(1))
    else $error("entry count changed by other than one");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> CW'(wr_addr) <= count_r)
    else $error("write beyond the list tail");

  a_dump_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> !pend_r)
    else $error("status pending during dump");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_stat_r != STAT_ENTRY) |-> out_last_r)
    else $error("status result without last");
`endif

endmodule
